// ----- src/anp_pkg.sv -----
// Package for the ASCII number parser.
// Holds the parse phase type and the character and limit constants.
// Used by ascii_number_parser.
package anp_pkg;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ZERO  = 3'd1,
    PH_DEC   = 3'd2,
    PH_HEX   = 3'd3
  } phase_t;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;

  localparam logic [31:0] LIM_UNSIGNED = 32'hFFFF_FFFF;
  localparam logic [31:0] LIM_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG      = 32'h8000_0000;

endpackage

// ----- src/anp_in_if.sv -----
// Input channel of the ASCII number parser: one character word per transfer.
// Depends on nothing but the valid/ready handshake.
interface anp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       signed_mode;
  logic       last;

  modport source (output valid, output ch, output signed_mode, output last, input ready);
  modport sink (input valid, input ch, input signed_mode, input last, output ready);
endinterface

// ----- src/anp_out_if.sv -----
// Output channel of the ASCII number parser: one result word per string.
// Depends on nothing but the valid/ready handshake.
interface anp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        valid_res;

  modport source (output valid, output value, output valid_res, input ready);
  modport sink (input valid, input value, input valid_res, output ready);
endinterface

// ----- src/ascii_number_parser.sv -----
// Top level of the ASCII number parser.
// Depends on anp_pkg, anp_in_if and anp_out_if.
//
// The block reads one character word per cycle, but a closing character waits while
// a result is still held; it returns one result word for every string, on the cycle
// after the closing character (last set) leaves the input register. A string in 0x or
// 0X form is unsigned hex saturating at all ones; otherwise it is decimal, signed or
// unsigned as signed_mode says on the first character. A malformed string gives
// value 0 with valid_res low. The rate is set by the single constant-multiply
// saturating accumulator update between the input and result registers.
module ascii_number_parser (
  input  logic     clk,
  input  logic     rst,
  anp_in_if.sink   din,
  anp_out_if.source dout
);

  logic             s1_valid;
  logic [7:0]       s1_ch;
  logic             s1_mode;
  logic             s1_last;

  anp_pkg::phase_t  phase, phase_next;
  logic [31:0]      acc, acc_next;
  logic             minus_seen, minus_seen_next;
  logic             bad_char, bad_char_next;
  logic             signed_latched, signed_latched_next;

  logic             out_valid;
  logic [31:0]      out_value;
  logic             out_res;

  logic             advance;
  logic             is_dig;
  logic [3:0]       dig;
  logic             is_hex;
  logic [3:0]       hex_dig;
  logic [31:0]      dec_lim;
  logic [35:0]      mul10;
  logic [35:0]      mul16;
  logic [31:0]      sat10;
  logic [31:0]      sat16;
  logic [31:0]      res_value;

  assign advance  = s1_valid && (!s1_last || !out_valid || dout.ready);
  assign din.ready = !s1_valid || advance;

  always_comb begin
    is_dig  = (s1_ch >= anp_pkg::CH_ZERO) && (s1_ch <= anp_pkg::CH_NINE);
    dig     = is_dig ? 4'(s1_ch - anp_pkg::CH_ZERO) : 4'd0;
    is_hex  = 1'b1;
    hex_dig = 4'd0;
    if (is_dig) begin
      hex_dig = dig;
    end else if ((s1_ch >= anp_pkg::CH_A_UP) && (s1_ch <= anp_pkg::CH_F_UP)) begin
      hex_dig = 4'(s1_ch - anp_pkg::CH_A_UP + 8'd10);
    end else if ((s1_ch >= anp_pkg::CH_A_LO) && (s1_ch <= anp_pkg::CH_F_LO)) begin
      hex_dig = 4'(s1_ch - anp_pkg::CH_A_LO + 8'd10);
    end else begin
      is_hex = 1'b0;
    end

    if (!signed_latched) begin
      dec_lim = anp_pkg::LIM_UNSIGNED;
    end else if (minus_seen) begin
      dec_lim = anp_pkg::LIM_NEG;
    end else begin
      dec_lim = anp_pkg::LIM_POS;
    end

    mul10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, dig};
    mul16 = {acc, 4'b0000} + {32'd0, hex_dig};
    sat10 = (mul10 > {4'd0, dec_lim}) ? dec_lim : mul10[31:0];
    sat16 = (mul16 > {4'd0, anp_pkg::LIM_UNSIGNED}) ? anp_pkg::LIM_UNSIGNED : mul16[31:0];
  end

  always_comb begin
    phase_next          = phase;
    acc_next            = acc;
    minus_seen_next     = minus_seen;
    bad_char_next       = bad_char;
    signed_latched_next = signed_latched;
    if (!bad_char) begin
      case (phase)
        anp_pkg::PH_START: begin
          signed_latched_next = s1_mode;
          if (s1_ch == anp_pkg::CH_MINUS) begin
            minus_seen_next = 1'b1;
            phase_next      = anp_pkg::PH_DEC;
          end else if (s1_ch == anp_pkg::CH_PLUS) begin
            phase_next = anp_pkg::PH_DEC;
          end else if (s1_ch == anp_pkg::CH_ZERO) begin
            phase_next = anp_pkg::PH_ZERO;
          end else if (is_dig) begin
            acc_next   = {28'd0, dig};
            phase_next = anp_pkg::PH_DEC;
          end else begin
            bad_char_next = 1'b1;
          end
        end
        anp_pkg::PH_ZERO: begin
          if ((s1_ch == anp_pkg::CH_X_LO) || (s1_ch == anp_pkg::CH_X_UP)) begin
            phase_next = anp_pkg::PH_HEX;
          end else if (is_dig) begin
            acc_next   = sat10;
            phase_next = anp_pkg::PH_DEC;
          end else begin
            bad_char_next = 1'b1;
          end
        end
        anp_pkg::PH_DEC: begin
          if (is_dig) begin
            acc_next = sat10;
          end else begin
            bad_char_next = 1'b1;
          end
        end
        anp_pkg::PH_HEX: begin
          if (is_hex) begin
            acc_next = sat16;
          end else begin
            bad_char_next = 1'b1;
          end
        end
        default: begin
          bad_char_next = 1'b1;
        end
      endcase
    end

    if ((phase_next != anp_pkg::PH_HEX) && minus_seen_next) begin
      res_value = 32'd0 - acc_next;
    end else begin
      res_value = acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
    if (din.ready && din.valid) begin
      s1_ch   <= din.ch;
      s1_mode <= din.signed_mode;
      s1_last <= din.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= anp_pkg::PH_START;
      acc            <= 32'd0;
      minus_seen     <= 1'b0;
      bad_char       <= 1'b0;
      signed_latched <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        phase          <= anp_pkg::PH_START;
        acc            <= 32'd0;
        minus_seen     <= 1'b0;
        bad_char       <= 1'b0;
        signed_latched <= 1'b0;
      end else begin
        phase          <= phase_next;
        acc            <= acc_next;
        minus_seen     <= minus_seen_next;
        bad_char       <= bad_char_next;
        signed_latched <= signed_latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_last) begin
      out_value <= bad_char_next ? 32'd0 : res_value;
      out_res   <= !bad_char_next;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.value     = out_value;
  assign dout.valid_res = out_res;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.valid_res) |-> (dout.value == 32'd0))
    else $error("invalid result carries a nonzero value");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> din.ready)
    else $error("input stalled with an empty input register");

  a_string_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> ((phase == anp_pkg::PH_START) && (acc == 32'd0) && !bad_char))
    else $error("state not cleared after the closing character");

  a_hex_no_minus: assert property (@(posedge clk) disable iff (rst)
    (phase == anp_pkg::PH_HEX) |-> !minus_seen)
    else $error("hex phase reached after a minus sign");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dout.ready) |-> !(advance && s1_last))
    else $error("result overwritten while still waiting");

endmodule
